FILE: rtl/pmva_pkg.sv
// shared types and constants of the power mode vote arbiter
// no dependencies
`default_nettype none
package pmva_pkg;
    localparam int NumModules    = 64;
    localparam int NumSleepLevels = 4;
    localparam int NumFreqLevels = 3;
    localparam int NumBusy       = 8;
    localparam int ModW  = (NumModules > 1) ? $clog2(NumModules) : 1;
    localparam int BusyW = (NumBusy > 1) ? $clog2(NumBusy) : 1;
    localparam int BcntW = $clog2(NumBusy + 1);
    // index width of the frequency vote table
    localparam int FlvW  = (NumFreqLevels > 2) ? $clog2(NumFreqLevels - 1) : 1;
    localparam logic [31:0] HalfRange = 32'h8000_0000;
    localparam int QDepth = 2;

    typedef enum logic [2:0] {
        OP_SLEEP_SET  = 3'd0,
        OP_SLEEP_CLR  = 3'd1,
        OP_FREQ_SET   = 3'd2,
        OP_FREQ_CLR   = 3'd3,
        OP_BUSY_SET   = 3'd4,
        OP_BUSY_CLR   = 3'd5,
        OP_DECIDE     = 3'd6,
        OP_WAKE       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_START_FREQ = 3'd1,
        REG_BUSY_CAP = 3'd2,
        REG_NEAR_TICKS = 3'd3,
        REG_NEAR_MODE = 3'd4,
        REG_TICKLESS = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t         op;
        logic        bad;
        logic [7:0]  id;
        logic [1:0]  level;
        logic [31:0] now;
        logic [31:0] busy_dl;
        logic        near;
        logic [31:0] lp_ticks;
        logic [31:0] new_tick;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  sleep_level;
        logic        enter_sleep;
        logic        lpt_start;
        logic [31:0] lptimer_ticks;
        logic        tick_update;
        logic [31:0] new_tick;
        logic        freq_change;
        logic [1:0]  freq_level;
        logic        freq_notify;
    } res_t;
endpackage
`default_nettype wire

FILE: rtl/power_mode_vote_arbiter_top.sv
// top level of the power mode vote arbiter: stream ports and register file
// depends on pmva_pkg, pmva_front, pmva_back
// a request passes the front queue, then the back end IDLE and OUT states; an enabled decide also runs SCAN
// the back end handles one request at a time and holds in OUT until the previous result is taken
// front queue holds two requests so input stays open while the back end works
// reset (aresetn low, synchronous) clears votes, busy deadlines and registers
`default_nettype none
module power_mode_vote_arbiter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[2:0], module id[10:3], level[12:11], now_tick[44:13], busy_ticks[76:45],
    // os_deadline[108:77], lptimer_deadline[140:109], elapsed_ticks[172:141]
    input  wire logic [175:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[0], sleep_level[2:1], enter_sleep[3], timer start[4], lptimer_ticks[36:5],
    // tick_update[37], new_tick[69:38], freq_change[70], freq_level[72:71], freq_notify[73]
    output logic [79:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic        en_reg;
    logic [1:0]  sfm_reg, bcap_reg, nmode_reg, tl_reg;
    logic [31:0] nticks_reg;
    logic        wr;
    logic [2:0]  ridx;
    logic        q_valid, q_ready;
    pmva_pkg::cmd_t q_cmd;
    pmva_pkg::res_t res;
    logic        freq_load;
    logic [1:0]  freq_val;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    // write of start frequency also loads current frequency, saturated
    assign freq_load = wr && (ridx == 3'(pmva_pkg::REG_START_FREQ)) && (paddr[1:0] == 2'd0);
    assign freq_val  = (pwdata[1:0] > 2'(pmva_pkg::NumFreqLevels - 1)) ?
                       2'(pmva_pkg::NumFreqLevels - 1) : pwdata[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg     <= 1'b0;
            sfm_reg    <= 2'd0;
            bcap_reg   <= 2'd1;
            nticks_reg <= 32'd2;
            nmode_reg  <= 2'd1;
            tl_reg     <= 2'd2;
        end else if (wr && paddr[1:0] == 2'd0) begin
            case (pmva_pkg::reg_idx_t'(ridx))
                pmva_pkg::REG_ENABLE:     en_reg     <= pwdata[0];
                pmva_pkg::REG_START_FREQ: sfm_reg    <= pwdata[1:0];
                pmva_pkg::REG_BUSY_CAP:   bcap_reg   <= pwdata[1:0];
                pmva_pkg::REG_NEAR_TICKS: nticks_reg <= pwdata;
                pmva_pkg::REG_NEAR_MODE:  nmode_reg  <= pwdata[1:0];
                pmva_pkg::REG_TICKLESS:   tl_reg     <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (pmva_pkg::reg_idx_t'(ridx))
            pmva_pkg::REG_ENABLE:     prdata = {31'd0, en_reg};
            pmva_pkg::REG_START_FREQ: prdata = {30'd0, sfm_reg};
            pmva_pkg::REG_BUSY_CAP:   prdata = {30'd0, bcap_reg};
            pmva_pkg::REG_NEAR_TICKS: prdata = nticks_reg;
            pmva_pkg::REG_NEAR_MODE:  prdata = {30'd0, nmode_reg};
            pmva_pkg::REG_TICKLESS:   prdata = {30'd0, tl_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    pmva_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .mode(s_tdata[2:0]), .src_id(s_tdata[10:3]), .level(s_tdata[12:11]),
        .now_tick(s_tdata[44:13]), .busy_ticks(s_tdata[76:45]),
        .os_deadline(s_tdata[108:77]), .lptimer_deadline(s_tdata[140:109]),
        .elapsed_ticks(s_tdata[172:141]), .near_ticks(nticks_reg),
        .q_valid, .q_ready, .q_cmd
    );

    pmva_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_cmd,
        .enable(en_reg), .busy_cap(bcap_reg), .near_mode(nmode_reg), .tickless(tl_reg),
        .freq_load, .freq_load_val(freq_val),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {6'd0, res.freq_notify, res.freq_level, res.freq_change, res.new_tick,
                      res.tick_update, res.lptimer_ticks, res.lpt_start,
                      res.enter_sleep, res.sleep_level, res.status};
endmodule
`default_nettype wire

FILE: rtl/pmva_front.sv
// front part: accepts requests, checks ranges, precomputes tick arithmetic
// depends on pmva_pkg
`default_nettype none
module pmva_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [2:0]       mode,
    input  wire logic [7:0]       src_id,
    input  wire logic [1:0]       level,
    input  wire logic [31:0]      now_tick,
    input  wire logic [31:0]      busy_ticks,
    input  wire logic [31:0]      os_deadline,
    input  wire logic [31:0]      lptimer_deadline,
    input  wire logic [31:0]      elapsed_ticks,
    input  wire logic [31:0]      near_ticks,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output pmva_pkg::cmd_t        q_cmd
);
    pmva_pkg::cmd_t q_reg [pmva_pkg::QDepth];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    pmva_pkg::cmd_t c;
    logic push, pop;

    always_comb begin
        c.op       = pmva_pkg::op_t'(mode);
        c.id       = src_id;
        c.level    = level;
        c.now      = now_tick;
        c.busy_dl  = now_tick + busy_ticks;
        c.near     = ((os_deadline - now_tick) <= near_ticks);
        c.lp_ticks = lptimer_deadline - now_tick;
        c.new_tick = now_tick + elapsed_ticks;
        case (pmva_pkg::op_t'(mode))
            pmva_pkg::OP_SLEEP_SET, pmva_pkg::OP_SLEEP_CLR:
                c.bad = ({24'd0, src_id} >= 32'(pmva_pkg::NumModules)) ||
                        ({30'd0, level} >= 32'(pmva_pkg::NumSleepLevels - 1));
            pmva_pkg::OP_FREQ_SET, pmva_pkg::OP_FREQ_CLR:
                c.bad = ({24'd0, src_id} >= 32'(pmva_pkg::NumModules)) ||
                        ({30'd0, level} >= 32'(pmva_pkg::NumFreqLevels - 1));
            pmva_pkg::OP_BUSY_SET:
                c.bad = ({24'd0, src_id} >= 32'(pmva_pkg::NumBusy)) ||
                        (busy_ticks == 32'd0) || (busy_ticks >= pmva_pkg::HalfRange);
            pmva_pkg::OP_BUSY_CLR:
                c.bad = ({24'd0, src_id} >= 32'(pmva_pkg::NumBusy));
            default: c.bad = 1'b0;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(pmva_pkg::QDepth));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= c;
    end
endmodule
`default_nettype wire

FILE: rtl/pmva_back.sv
// back part: vote state, sequential busy scan, decision and wake handling
// depends on pmva_pkg
`default_nettype none
module pmva_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire pmva_pkg::cmd_t   q_cmd,
    input  wire logic             enable,
    input  wire logic [1:0]       busy_cap,
    input  wire logic [1:0]       near_mode,
    input  wire logic [1:0]       tickless,
    input  wire logic             freq_load,
    input  wire logic [1:0]       freq_load_val,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pmva_pkg::res_t        out_res
);
    localparam int SL = pmva_pkg::NumSleepLevels - 1;
    localparam int FL = pmva_pkg::NumFreqLevels - 1;

    logic [pmva_pkg::NumModules-1:0] svote_reg [SL];
    logic [pmva_pkg::NumModules-1:0] fvote_reg [FL];
    logic [31:0] busy_reg [pmva_pkg::NumBusy];
    logic [1:0]  chosen_reg, cur_freq_reg;
    logic        pend_reg, armed_reg;
    pmva_pkg::state_t st_reg, st_next;
    logic [pmva_pkg::BcntW-1:0] idx_reg;
    logic        anyb_reg;
    pmva_pkg::res_t res_reg, res_next;
    logic        ovld_reg;
    logic        fire;

    logic [1:0] first_s, first_f, pick;
    logic [pmva_pkg::ModW-1:0] mid;
    logic [pmva_pkg::BusyW-1:0] bid;
    logic [pmva_pkg::FlvW-1:0] flv;

    assign mid = q_cmd.id[pmva_pkg::ModW-1:0];
    assign bid = q_cmd.id[pmva_pkg::BusyW-1:0];
    assign flv = q_cmd.level[pmva_pkg::FlvW-1:0];

    always_comb begin
        first_s = 2'(SL);
        for (int l = SL - 1; l >= 0; l--)
            if (|svote_reg[l]) first_s = 2'(l);
        first_f = 2'(FL);
        for (int l = FL - 1; l >= 0; l--)
            if (|fvote_reg[l]) first_f = 2'(l);
        pick = first_s;
        if (anyb_reg && busy_cap < pick) pick = busy_cap;
        if (q_cmd.near && near_mode < pick) pick = near_mode;
    end

    assign out_valid = ovld_reg;
    assign out_res   = res_reg;
    assign fire      = (st_reg == pmva_pkg::ST_OUT) && !ovld_reg;
    assign q_ready   = fire;

    // result of the request at the head of the queue
    always_comb begin
        res_next             = '0;
        res_next.status      = q_cmd.bad;
        res_next.sleep_level = chosen_reg;
        res_next.freq_level  = cur_freq_reg;
        case (q_cmd.op)
            pmva_pkg::OP_FREQ_SET:
                if (!q_cmd.bad && q_cmd.level < cur_freq_reg) begin
                    res_next.freq_level  = q_cmd.level;
                    res_next.freq_change = 1'b1;
                end
            pmva_pkg::OP_DECIDE:
                if (!enable) begin
                    res_next.status = 1'b1;
                end else begin
                    res_next.sleep_level = pick;
                    res_next.enter_sleep = 1'b1;
                    if (pick >= tickless) begin
                        res_next.lpt_start     = 1'b1;
                        res_next.lptimer_ticks = q_cmd.lp_ticks;
                    end
                end
            pmva_pkg::OP_WAKE: begin
                if (armed_reg) begin
                    res_next.tick_update = 1'b1;
                    res_next.new_tick    = q_cmd.new_tick;
                end
                if (pend_reg && first_f != cur_freq_reg) begin
                    res_next.freq_level  = first_f;
                    res_next.freq_change = 1'b1;
                    res_next.freq_notify = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            pmva_pkg::ST_IDLE:
                if (q_valid) begin
                    if (q_cmd.op == pmva_pkg::OP_DECIDE && enable)
                        st_next = pmva_pkg::ST_SCAN;
                    else
                        st_next = pmva_pkg::ST_OUT;
                end
            pmva_pkg::ST_SCAN:
                if (idx_reg == pmva_pkg::BcntW'(pmva_pkg::NumBusy - 1))
                    st_next = pmva_pkg::ST_OUT;
            pmva_pkg::ST_OUT:
                if (!ovld_reg) st_next = pmva_pkg::ST_IDLE;
            default: st_next = pmva_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= pmva_pkg::ST_IDLE;
        else          st_reg <= st_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < SL; l++) svote_reg[l] <= '0;
            for (int l = 0; l < FL; l++) fvote_reg[l] <= '0;
            for (int i = 0; i < pmva_pkg::NumBusy; i++) busy_reg[i] <= 32'd0;
            chosen_reg   <= 2'(SL);
            cur_freq_reg <= 2'd0;
            pend_reg     <= 1'b0;
            armed_reg    <= 1'b0;
            ovld_reg     <= 1'b0;
            idx_reg      <= '0;
            anyb_reg     <= 1'b0;
        end else begin
            if (freq_load) cur_freq_reg <= freq_load_val;
            else if (fire) cur_freq_reg <= res_next.freq_level;
            if (ovld_reg && out_ready) ovld_reg <= 1'b0;
            if (st_reg == pmva_pkg::ST_IDLE) begin
                idx_reg  <= '0;
                anyb_reg <= 1'b0;
            end
            if (st_reg == pmva_pkg::ST_SCAN) begin
                if (busy_reg[idx_reg[pmva_pkg::BusyW-1:0]] > q_cmd.now) anyb_reg <= 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
            if (fire) begin
                ovld_reg   <= 1'b1;
                res_reg    <= res_next;
                chosen_reg <= res_next.sleep_level;
                if (res_next.lpt_start) armed_reg <= 1'b1;
                else if (q_cmd.op == pmva_pkg::OP_WAKE) armed_reg <= 1'b0;
                case (q_cmd.op)
                    pmva_pkg::OP_SLEEP_SET:
                        if (!q_cmd.bad) svote_reg[q_cmd.level][mid] <= 1'b1;
                    pmva_pkg::OP_SLEEP_CLR:
                        if (!q_cmd.bad) svote_reg[q_cmd.level][mid] <= 1'b0;
                    pmva_pkg::OP_FREQ_SET:
                        if (!q_cmd.bad) fvote_reg[flv][mid] <= 1'b1;
                    pmva_pkg::OP_FREQ_CLR:
                        if (!q_cmd.bad) begin
                            fvote_reg[flv][mid] <= 1'b0;
                            pend_reg <= 1'b1;
                        end
                    pmva_pkg::OP_BUSY_SET:
                        if (!q_cmd.bad) busy_reg[bid] <= q_cmd.busy_dl;
                    pmva_pkg::OP_BUSY_CLR:
                        if (!q_cmd.bad) busy_reg[bid] <= 32'd0;
                    pmva_pkg::OP_WAKE:
                        pend_reg <= 1'b0;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire
